// File: hw/rtl/sef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sef_pkg;

   // ring buffer geometry
   localparam int CAPACITY = 1024;
   localparam int KEY_BITS = 32;
   localparam int PTR_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

   // field widths
   localparam int TIME_W   = 64;
   localparam int KEY_W    = 32;
   localparam int OP_W     = 2;
   localparam int LAT_W    = 32;
   localparam int FILL_W   = 10;
   localparam int CNT_W    = 32;
   localparam int RATE_W   = 14;
   localparam int SEED_W   = 64;
   localparam int STATUS_W = 3;

   // stored entry: time, key, latency, opcode, hit
   localparam int ENTRY_W = TIME_W + KEY_BITS + LAT_W + OP_W + 1;

   // stream payload sizes
   localparam int EVT_FIELDS_W = TIME_W + KEY_W + OP_W + 1 + LAT_W;
   localparam int REQ_DATA_W   = ((EVT_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_PAD_W    = REQ_DATA_W - EVT_FIELDS_W;
   localparam int RSP_FIELDS_W = EVT_FIELDS_W + FILL_W + 4 * CNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [RATE_W-1:0] RATE_FULL = RATE_W'(10000);
   localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

   // random draw reduction modulo 10000
   localparam int MOD_K       = 10000;
   localparam int SUM_W       = 31;
   localparam int PROD_W      = 63;
   localparam int RECIP_SHIFT = 45;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;
   localparam int REM2_W      = 15;
   localparam logic [SUM_W-1:0] W16 = SUM_W'(5536);   // 2^16 mod 10000
   localparam logic [SUM_W-1:0] W32 = SUM_W'(7296);   // 2^32 mod 10000
   localparam logic [SUM_W-1:0] W48 = SUM_W'(656);    // 2^48 mod 10000
   localparam logic [31:0] RECIP = 32'd3518437208;    // floor(2^45 / 10000)
   localparam int DRAW_DEPTH = 8;
   localparam int DRAW_PTR_W = $clog2(DRAW_DEPTH);
   localparam int DRAW_CNT_W = $clog2(DRAW_DEPTH + 1);

   // register indexes, decoded from the address bit above the 8-byte slot
   typedef enum logic {
      REG_SAMPLE_RATE,
      REG_SEED
   } csr_reg_type;

   typedef enum logic {
      REQ_LOG,
      REQ_POP
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NOT_SAMPLED,
      ST_STORED,
      ST_DROPPED,
      ST_POPPED,
      ST_POP_EMPTY
   } status_type;

   // request payload, first field in the lowest bits
   typedef struct packed {
      logic [REQ_PAD_W-1:0] pad;
      logic [LAT_W-1:0]     latency;
      logic                 hit;
      logic [OP_W-1:0]      op_code;
      logic [KEY_W-1:0]     key_id;
      logic [TIME_W-1:0]    timestamp;
   } req_data_type;

   // result payload, first field in the lowest bits
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [CNT_W-1:0]     exported_count;
      logic [CNT_W-1:0]     dropped_count;
      logic [CNT_W-1:0]     sampled_count;
      logic [CNT_W-1:0]     total_count;
      logic [FILL_W-1:0]    fill_level;
      logic [LAT_W-1:0]     out_latency;
      logic                 out_hit;
      logic [OP_W-1:0]      out_op_code;
      logic [KEY_W-1:0]     out_key_id;
      logic [TIME_W-1:0]    out_timestamp;
   } rsp_data_type;

   // control into the draw unit
   typedef struct packed {
      logic              load;
      logic              take;
      logic [SEED_W-1:0] seed;
   } draw_ctl_type;

   // status out of the draw unit
   typedef struct packed {
      logic              avail;
      logic [RATE_W-1:0] rem;
   } draw_stat_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] r);
      return (w >= r) ? (w - r) : (PTR_W'(CAPACITY) - r + w);
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sef_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/sef_draw.sv
`timescale 1ns / 1ps
`default_nettype none

module sef_draw (
   input  logic                   clock,
   input  logic                   reset,
   input  sef_pkg::draw_ctl_type  ctl,
   output sef_pkg::draw_stat_type stat
);
   import sef_pkg::*;

   logic [SEED_W-1:0] gen_ff;
   logic [SEED_W-1:0] gen_step;
   logic [SEED_W-1:0] seed_fix;
   logic              issue;

   logic [DRAW_CNT_W-1:0] credit_ff;
   logic [DRAW_CNT_W-1:0] credit_in;

   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic [SEED_W-1:0] x1_ff;
   logic [SUM_W-1:0]  s2_ff, s2_in;
   logic [SUM_W-1:0]  s3_ff;
   logic [PROD_W-1:0] p3_ff, p3_in;
   logic [QUO_W-1:0]  q4;
   logic [SUM_W-1:0]  r4_in;
   logic [REM2_W-1:0] r4_ff;
   logic [RATE_W-1:0] rem5;

   logic [RATE_W-1:0]     dq_ff [DRAW_DEPTH];
   logic [DRAW_PTR_W-1:0] dq_wp_ff, dq_rp_ff;
   logic [DRAW_CNT_W-1:0] dq_cnt_ff, dq_cnt_in;

   // xorshift64 step, shifts 13, 7, 17
   always_comb begin
      gen_step = gen_ff ^ (gen_ff << 13);
      gen_step = gen_step ^ (gen_step >> 7);
      gen_step = gen_step ^ (gen_step << 17);
   end

   assign seed_fix = (ctl.seed == '0) ? SEED_W'(1) : ctl.seed;

   // run ahead only as far as the draw queue can hold
   assign issue     = !ctl.load && (credit_ff < DRAW_CNT_W'(DRAW_DEPTH));
   assign credit_in = credit_ff + DRAW_CNT_W'(issue) - DRAW_CNT_W'(ctl.take);

   // fold 16-bit chunks by their weights modulo 10000
   assign s2_in = SUM_W'(x1_ff[63:48]) * W48 + SUM_W'(x1_ff[47:32]) * W32 +
                  SUM_W'(x1_ff[31:16]) * W16 + SUM_W'(x1_ff[15:0]);

   // reciprocal multiply, quotient low by at most one
   assign p3_in = PROD_W'(s2_ff) * PROD_W'(RECIP);
   assign q4    = p3_ff[PROD_W-1:RECIP_SHIFT];
   assign r4_in = s3_ff - SUM_W'(q4) * SUM_W'(MOD_K);

   // final correction, remainder below 20000
   assign rem5 = (r4_ff >= REM2_W'(MOD_K)) ? RATE_W'(r4_ff - REM2_W'(MOD_K))
                                           : RATE_W'(r4_ff);

   assign dq_cnt_in = dq_cnt_ff + DRAW_CNT_W'(v4_ff) - DRAW_CNT_W'(ctl.take);

   // generator, stage valids and queue control
   always_ff @(posedge clock) begin
      if (reset || ctl.load) begin
         gen_ff    <= reset ? SEED_W'(1) : seed_fix;
         credit_ff <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         dq_wp_ff  <= '0;
         dq_rp_ff  <= '0;
         dq_cnt_ff <= '0;
      end else begin
         if (issue) begin
            gen_ff <= gen_step;
         end
         credit_ff <= credit_in;
         v1_ff     <= issue;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         if (v4_ff) begin
            dq_wp_ff <= dq_wp_ff + 1'b1;
         end
         if (ctl.take) begin
            dq_rp_ff <= dq_rp_ff + 1'b1;
         end
         dq_cnt_ff <= dq_cnt_in;
      end
   end

   // datapath stages and queue storage
   always_ff @(posedge clock) begin
      x1_ff <= gen_step;
      s2_ff <= s2_in;
      s3_ff <= s2_ff;
      p3_ff <= p3_in;
      r4_ff <= r4_in[REM2_W-1:0];
      if (v4_ff) begin
         dq_ff[dq_wp_ff] <= rem5;
      end
   end

   assign stat.avail = (dq_cnt_ff != '0);
   assign stat.rem   = dq_ff[dq_rp_ff];

endmodule

`default_nettype wire

// File: hw/rtl/sampled_event_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Sampled trace capture FIFO.
// req channel: each beat is an access event (req_tuser = 0) or a pop (req_tuser = 1).
// An event is counted and, at the programmed sample rate, written to a ring
// buffer of CAPACITY slots holding at most CAPACITY-1 entries; a full buffer
// counts a drop. A pop returns the oldest entry or reports empty.
// rsp channel: exactly one beat per req beat, in order; rsp_tuser is the status.
// A result passes the read stage, registered with the read of the entry store,
// then the result buffer that drives rsp_tvalid. Throughput: one beat per cycle while req_tready is high.
// Fractional rates draw from an xorshift64 generator that runs ahead through a
// five-stage modulo pipeline into an eight-entry draw queue; after reset or a
// seed write, events wait until the first draw has reached the draw queue.
// Up to four results are held when rsp_tready is low; then req_tready drops.
// Reset empties the ring, clears the counters and the result buffer, and sets
// the sample rate to 10000 and the seed to 1. CSR: 0x0 sample rate (clamped
// to 10000 from the low 14 bits), 0x8 seed (zero is stored, the generator starts from one).

module sampled_event_fifo (
   input  logic                                clock,
   input  logic                                reset,
   // request beats
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // timestamp, key_id, op_code, hit, latency, zero pad
   input  logic [sef_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type
   input  logic                                req_tuser,
   // result beats
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_timestamp, out_key_id, out_op_code, out_hit, out_latency, fill_level,
   // total_count, sampled_count, dropped_count, exported_count, zero pad
   output logic [sef_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status
   output logic [sef_pkg::STATUS_W-1:0]        rsp_tuser,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sef_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sef_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sef_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import sef_pkg::*;

   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   typedef struct packed {
      logic              hit;
      logic [OP_W-1:0]   op_code;
      logic [LAT_W-1:0]  latency;
      logic [KEY_BITS-1:0] key;
      logic [TIME_W-1:0] timestamp;
   } entry_type;

   typedef struct packed {
      status_type   status;
      rsp_data_type data;
   } rsp_entry_type;

   // configuration
   logic              csr_wr;
   csr_reg_type       csr_reg;
   logic [RATE_W-1:0] wr_rate;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [SEED_W-1:0] seed_ff, seed_in;

   draw_ctl_type  draw_ctl;
   draw_stat_type draw_stat;

   // request side
   req_data_type req_d;
   logic         accept;
   logic         is_pop;
   logic         rate_full, rate_zero, draw_ok;
   logic         sampled, is_full, is_empty;
   logic [PTR_W-1:0] wr_next, rd_next;
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] total_ff, total_in, samp_ff, samp_in;
   logic [CNT_W-1:0] drop_ff, drop_in, exp_ff, exp_in;
   status_type       status_a;
   logic             ram_we;
   entry_type        wr_entry, rd_entry;

   // read stage and result buffer
   logic          b_valid_ff;
   status_type    b_status_ff;
   rsp_entry_type push_entry;
   logic          oq_push, oq_pop;
   rsp_entry_type oq_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] oq_wp_ff, oq_rp_ff;
   logic [OQ_CNT_W-1:0] oq_cnt_ff, oq_cnt_in;

   // register port decode
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1]);
   assign wr_rate    = csr_pwdata[RATE_W-1:0];

   always_comb begin
      rate_in = rate_ff;
      seed_in = seed_ff;
      if (csr_wr) begin
         unique case (csr_reg)
            REG_SAMPLE_RATE: rate_in = (wr_rate > RATE_FULL) ? RATE_FULL : wr_rate;
            REG_SEED:        seed_in = csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_SAMPLE_RATE: csr_prdata = CSR_DATA_W'(rate_ff);
         REG_SEED:        csr_prdata = seed_ff;
      endcase
   end

   // random draws
   assign draw_ctl.load = csr_wr && (csr_reg == REG_SEED);
   assign draw_ctl.seed = csr_pwdata;
   assign draw_ctl.take = accept && !is_pop && !rate_full && !rate_zero;

   sef_draw u_draw (
      .clock (clock),
      .reset (reset),
      .ctl   (draw_ctl),
      .stat  (draw_stat)
   );

   // accept when a buffer slot is free and a draw is ready if needed
   assign req_d     = req_data_type'(req_tdata);
   assign is_pop    = (req_kind_type'(req_tuser) == REQ_POP);
   assign rate_full = (rate_ff == RATE_FULL);
   assign rate_zero = (rate_ff == '0);
   assign draw_ok   = rate_full || rate_zero || draw_stat.avail;
   assign req_tready = ((oq_cnt_ff + OQ_CNT_W'(b_valid_ff)) < OQ_CNT_W'(OQ_DEPTH)) && draw_ok;
   assign accept    = req_tvalid && req_tready;

   // sample decision, ring pointers and counters
   assign wr_next  = ptr_next(wptr_ff);
   assign rd_next  = ptr_next(rptr_ff);
   assign is_full  = (wr_next == rptr_ff);
   assign is_empty = (rptr_ff == wptr_ff);
   assign sampled  = rate_full || (!rate_zero && (draw_stat.rem < rate_ff));

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      total_in = total_ff;
      samp_in  = samp_ff;
      drop_in  = drop_ff;
      exp_in   = exp_ff;
      status_a = ST_NOT_SAMPLED;
      ram_we   = 1'b0;
      if (accept) begin
         if (!is_pop) begin
            total_in = sat_inc(total_ff);
            if (sampled) begin
               if (is_full) begin
                  drop_in  = sat_inc(drop_ff);
                  status_a = ST_DROPPED;
               end else begin
                  ram_we   = 1'b1;
                  wptr_in  = wr_next;
                  samp_in  = sat_inc(samp_ff);
                  status_a = ST_STORED;
               end
            end
         end else if (is_empty) begin
            status_a = ST_POP_EMPTY;
         end else begin
            rptr_in  = rd_next;
            exp_in   = sat_inc(exp_ff);
            status_a = ST_POPPED;
         end
      end
   end

   // entry store
   assign wr_entry.hit       = req_d.hit;
   assign wr_entry.op_code   = req_d.op_code;
   assign wr_entry.latency   = req_d.latency;
   assign wr_entry.key       = KEY_BITS'(req_d.key_id);
   assign wr_entry.timestamp = req_d.timestamp;

   sef_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wptr_ff),
      .wdata (wr_entry),
      .raddr (rptr_ff),
      .rdata (rd_entry)
   );

   // result beat: pointers and counters already hold this item's outcome
   always_comb begin
      push_entry.status              = b_status_ff;
      push_entry.data                = '0;
      push_entry.data.fill_level     = FILL_W'(ring_fill(wptr_ff, rptr_ff));
      push_entry.data.total_count    = total_ff;
      push_entry.data.sampled_count  = samp_ff;
      push_entry.data.dropped_count  = drop_ff;
      push_entry.data.exported_count = exp_ff;
      if (b_status_ff == ST_POPPED) begin
         push_entry.data.out_timestamp = rd_entry.timestamp;
         push_entry.data.out_key_id    = KEY_W'(rd_entry.key);
         push_entry.data.out_op_code   = rd_entry.op_code;
         push_entry.data.out_hit       = rd_entry.hit;
         push_entry.data.out_latency   = rd_entry.latency;
      end
   end

   // result buffer
   assign oq_push   = b_valid_ff;
   assign oq_pop    = rsp_tvalid && rsp_tready;
   assign oq_cnt_in = oq_cnt_ff + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);

   assign rsp_tvalid = (oq_cnt_ff != '0);
   assign rsp_tdata  = oq_ff[oq_rp_ff].data;
   assign rsp_tuser  = oq_ff[oq_rp_ff].status;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff     <= RATE_FULL;
         seed_ff     <= SEED_W'(1);
         wptr_ff     <= '0;
         rptr_ff     <= '0;
         total_ff    <= '0;
         samp_ff     <= '0;
         drop_ff     <= '0;
         exp_ff      <= '0;
         b_valid_ff  <= 1'b0;
         b_status_ff <= ST_NOT_SAMPLED;
         oq_wp_ff    <= '0;
         oq_rp_ff    <= '0;
         oq_cnt_ff   <= '0;
      end else begin
         rate_ff     <= rate_in;
         seed_ff     <= seed_in;
         wptr_ff     <= wptr_in;
         rptr_ff     <= rptr_in;
         total_ff    <= total_in;
         samp_ff     <= samp_in;
         drop_ff     <= drop_in;
         exp_ff      <= exp_in;
         b_valid_ff  <= accept;
         b_status_ff <= status_a;
         if (oq_push) begin
            oq_wp_ff <= oq_wp_ff + 1'b1;
         end
         if (oq_pop) begin
            oq_rp_ff <= oq_rp_ff + 1'b1;
         end
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   // result buffer storage
   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wp_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/sef_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sef_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sef_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [sef_pkg::STATUS_W-1:0]   rsp_tuser
);
   import sef_pkg::*;

   rsp_data_type rd;

   assign rd = rsp_data_type'(rsp_tdata);

   // a stalled result beat stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat withdrawn under stall");

   // a stalled result beat keeps its payload
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed under stall");

   // only a successful pop carries entry data
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_POPPED) |->
         (rd.out_timestamp == '0) && (rd.out_key_id == '0) &&
         (rd.out_op_code == '0) && (rd.out_hit == 1'b0) && (rd.out_latency == '0))
      else $error("entry data on a beat that is not a pop");

   // an empty pop sees an empty ring
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_POP_EMPTY) |-> (rd.fill_level == '0))
      else $error("empty pop with nonzero fill level");

   // a drop happens only with the ring full
   a_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_DROPPED) |->
         (rd.fill_level == FILL_W'(CAPACITY - 1)))
      else $error("drop reported with ring not full");

endmodule

bind sampled_event_fifo sef_checker u_checker (.*);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import sef_pkg::*;

   localparam int HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int HOLD_BEATS  = 40;     // events offered behind the hold-off
   localparam int QUIET_LIMIT = 5000;   // cycles with no beat before giving up
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_BEATS = 40;
   localparam int RANDOM_PHASES = 7;

   // access opcodes carried in the event
   localparam logic [OP_W-1:0] OP_GET    = 2'd0;
   localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_OTHER  = 2'd3;

   localparam logic [KEY_W-1:0] KEY_KEEP =
      (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << KEY_BITS) - 1);

   typedef struct packed {
      status_type   status;
      rsp_data_type data;
   } capture_result_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // timestamp, key_id, op_code, hit, latency, zero pad
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   // req_type
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // out_timestamp, out_key_id, out_op_code, out_hit, out_latency, fill_level,
   // total_count, sampled_count, dropped_count, exported_count, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // status
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow copy of the capture block
   logic [RATE_W-1:0] sh_rate = RATE_FULL;
   logic [SEED_W-1:0] sh_seed = 64'd1;
   logic [SEED_W-1:0] sh_rng  = 64'd1;
   int                sh_rd   = 0;
   int                sh_wr   = 0;
   req_data_type      sh_ring [CAPACITY];
   logic [CNT_W-1:0]  sh_total    = '0;
   logic [CNT_W-1:0]  sh_sampled  = '0;
   logic [CNT_W-1:0]  sh_dropped  = '0;
   logic [CNT_W-1:0]  sh_exported = '0;

   capture_result_type expected_captures[$];

   int  mismatch_count  = 0;
   int  beats_sent      = 0;
   int  results_checked = 0;
   int  status_hits[5]  = '{default: 0};
   int  deepest_fill    = 0;
   int  hold_asks       = 0;
   int  hold_served     = 0;
   int  hold_left       = 0;
   int  stall_left      = 0;
   int  quiet_cycles    = 0;
   logic idle_on        = 1'b1;

   always #2 clock = ~clock;

   sampled_event_fifo u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------------
   // shadow model

   function automatic logic [63:0] xorshift_advance(input logic [63:0] x);
      x = x ^ (x << 13);
      x = x ^ (x >> 7);
      x = x ^ (x << 17);
      return x;
   endfunction

   function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
   endfunction

   // register write as the block applies it
   task automatic shadow_config(input csr_reg_type r, input logic [CSR_DATA_W-1:0] value);
      logic [RATE_W-1:0] rate_bits;
      rate_bits = value[RATE_W-1:0];
      if (r == REG_SAMPLE_RATE) begin
         sh_rate = (rate_bits > RATE_FULL) ? RATE_FULL : rate_bits;
      end else begin
         sh_seed = value;
         sh_rng  = (value == '0) ? 64'd1 : value;
      end
   endtask

   // one accepted request beat -> one expected result beat
   task automatic predict_capture(input req_kind_type kind, input req_data_type evt);
      capture_result_type res;
      logic keep;
      int nxt;
      res = '0;
      if (kind == REQ_LOG) begin
         sh_total = count_up(sh_total);
         if (sh_rate >= RATE_FULL) begin
            keep = 1'b1;
         end else if (sh_rate == '0) begin
            keep = 1'b0;
         end else begin
            sh_rng = xorshift_advance(sh_rng);
            keep = (sh_rng % 64'd10000) < 64'(sh_rate);
         end
         if (!keep) begin
            res.status = ST_NOT_SAMPLED;
         end else begin
            nxt = (sh_wr + 1) % CAPACITY;
            if (nxt == sh_rd) begin
               sh_dropped = count_up(sh_dropped);
               res.status = ST_DROPPED;
            end else begin
               sh_ring[sh_wr] = evt;
               sh_ring[sh_wr].key_id = evt.key_id & KEY_KEEP;
               sh_wr = nxt;
               sh_sampled = count_up(sh_sampled);
               res.status = ST_STORED;
            end
         end
      end else if (sh_rd == sh_wr) begin
         res.status = ST_POP_EMPTY;
      end else begin
         res.data.out_timestamp = sh_ring[sh_rd].timestamp;
         res.data.out_key_id    = sh_ring[sh_rd].key_id;
         res.data.out_op_code   = sh_ring[sh_rd].op_code;
         res.data.out_hit       = sh_ring[sh_rd].hit;
         res.data.out_latency   = sh_ring[sh_rd].latency;
         sh_rd = (sh_rd + 1) % CAPACITY;
         sh_exported = count_up(sh_exported);
         res.status = ST_POPPED;
      end
      res.data.fill_level     = FILL_W'((sh_wr - sh_rd + CAPACITY) % CAPACITY);
      res.data.total_count    = sh_total;
      res.data.sampled_count  = sh_sampled;
      res.data.dropped_count  = sh_dropped;
      res.data.exported_count = sh_exported;
      expected_captures.insert(expected_captures.size(), res);
   endtask

   // ---------------------------------------------------------------------
   // result checking

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at result %0d, %s: expected %h, got %h",
                  results_checked, what, want, got);
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) note_mismatch(what, want, got);
   endtask

   always @(posedge clock) begin : check_results
      rsp_data_type       got;
      capture_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_captures.size() == 0) begin
            note_mismatch("result beat with nothing pending", '0, 64'(rsp_tuser));
         end else begin
            want = expected_captures.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_tuser));
            check_field("out_timestamp", want.data.out_timestamp, got.out_timestamp);
            check_field("out_key_id", 64'(want.data.out_key_id), 64'(got.out_key_id));
            check_field("out_op_code", 64'(want.data.out_op_code), 64'(got.out_op_code));
            check_field("out_hit", 64'(want.data.out_hit), 64'(got.out_hit));
            check_field("out_latency", 64'(want.data.out_latency), 64'(got.out_latency));
            check_field("fill_level", 64'(want.data.fill_level), 64'(got.fill_level));
            check_field("total_count", 64'(want.data.total_count), 64'(got.total_count));
            check_field("sampled_count", 64'(want.data.sampled_count),
                        64'(got.sampled_count));
            check_field("dropped_count", 64'(want.data.dropped_count),
                        64'(got.dropped_count));
            check_field("exported_count", 64'(want.data.exported_count),
                        64'(got.exported_count));
            if (int'(want.data.fill_level) > deepest_fill)
               deepest_fill = int'(want.data.fill_level);
         end
         if (rsp_tuser < 3'd5) status_hits[rsp_tuser]++;
         results_checked++;
      end
   end

   // result-side ready: long hold-offs on request, else random stall bursts
   always @(posedge clock) begin : drive_rsp_ready
      if (hold_asks != hold_served) begin
         hold_served <= hold_asks;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // give up when no beat moves for too long
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d results pending",
                  quiet_cycles, expected_captures.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // drivers

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(input csr_reg_type r);
      return CSR_ADDR_W'(8 * int'(r));
   endfunction

   task automatic csr_write(input csr_reg_type r, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= reg_addr(r);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      shadow_config(r, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // read back a register and compare with the shadow copy
   task automatic check_register(input csr_reg_type r);
      logic [CSR_DATA_W-1:0] got;
      logic [CSR_DATA_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= reg_addr(r);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got  = csr_prdata;
      want = (r == REG_SAMPLE_RATE) ? CSR_DATA_W'(sh_rate) : sh_seed;
      if (got !== want) note_mismatch(r.name(), want, got);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input csr_reg_type r, input logic [CSR_DATA_W-1:0] value);
      csr_write(r, value);
      check_register(r);
   endtask

   // offer one request beat, with an occasional gap before it
   task automatic send_beat(input req_kind_type kind, input req_data_type d);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      predict_capture(kind, d);
      beats_sent++;
   endtask

   // stop offering and let every pending result come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_captures.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic req_data_type random_event();
      req_data_type d;
      d = '0;
      d.timestamp = {$urandom, $urandom};
      d.key_id    = $urandom;
      d.op_code   = OP_W'($urandom_range(0, 3));
      d.hit       = 1'($urandom_range(0, 1));
      d.latency   = $urandom;
      // pull some fields to their extremes
      case ($urandom_range(0, 9))
         0: d.timestamp = '0;
         1: d.timestamp = '1;
         2: d.key_id = '0;
         3: d.key_id = '1;
         4: d.latency = '0;
         5: d.latency = '1;
         default: ;
      endcase
      return d;
   endfunction

   function automatic req_data_type make_event(input logic [TIME_W-1:0] ts,
                                               input logic [KEY_W-1:0] key,
                                               input logic [OP_W-1:0] op,
                                               input logic hit,
                                               input logic [LAT_W-1:0] lat);
      req_data_type d;
      d = '0;
      d.timestamp = ts;
      d.key_id    = key;
      d.op_code   = op;
      d.hit       = hit;
      d.latency   = lat;
      return d;
   endfunction

   // ---------------------------------------------------------------------
   // tests

   task automatic test_register_reset();
      check_register(REG_SAMPLE_RATE);
      check_register(REG_SEED);
   endtask

   // field extremes and every opcode at full rate, read back in order
   task automatic test_directed();
      send_beat(REQ_POP, '0);
      send_beat(REQ_LOG, make_event('0, '0, OP_GET, 1'b0, '0));
      send_beat(REQ_LOG, make_event('1, '1, OP_OTHER, 1'b1, '1));
      send_beat(REQ_LOG, make_event(64'h8000_0000_0000_0001, 32'h8000_0001, OP_PUT,
                                    1'b1, 32'h0000_ffff));
      send_beat(REQ_LOG, make_event(64'h5555_aaaa_5555_aaaa, 32'haaaa_5555, OP_DELETE,
                                    1'b0, 32'hffff_0000));
      send_beat(REQ_LOG, make_event(64'h0123_4567_89ab_cdef, 32'hdead_beef, OP_OTHER,
                                    1'b0, 32'h1));
      // pops carry junk in the event fields, which must be ignored
      repeat (6) send_beat(REQ_POP, random_event());
      send_beat(REQ_LOG, random_event());
      send_beat(REQ_POP, random_event());
      wait_for_results();
   endtask

   // rate and seed corners: never, clamped, wide writes, zero seed
   task automatic test_rate_extremes();
      set_config(REG_SAMPLE_RATE, '0);
      repeat (6) send_beat(REQ_LOG, random_event());
      send_beat(REQ_POP, random_event());
      wait_for_results();
      set_config(REG_SAMPLE_RATE, 64'd16383);
      repeat (3) send_beat(REQ_LOG, random_event());
      wait_for_results();
      set_config(REG_SAMPLE_RATE, 64'd10001);
      set_config(REG_SAMPLE_RATE, 64'hffff_ffff_ffff_0001);
      repeat (4) send_beat(REQ_LOG, random_event());
      wait_for_results();
      // zero seed is kept in the register, generator starts from one
      set_config(REG_SEED, '0);
      set_config(REG_SAMPLE_RATE, 64'd5000);
      repeat (10) send_beat(REQ_LOG, random_event());
      repeat (12) send_beat(REQ_POP, random_event());
      wait_for_results();
   endtask

   // events offered behind a long result hold-off, so the block stalls its input,
   // then drained by pops past empty
   task automatic test_receiver_hold();
      set_config(REG_SAMPLE_RATE, 64'd10000);
      hold_asks <= hold_asks + 1;
      repeat (HOLD_BEATS) send_beat(REQ_LOG, random_event());
      wait_for_results();
      repeat (HOLD_BEATS + 2) send_beat(REQ_POP, random_event());
      wait_for_results();
   endtask

   // random mixes of events and pops over a range of rates and seeds
   task automatic test_random();
      req_kind_type kind;
      int pop_pct;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_results();
         case (p)
            0: set_config(REG_SAMPLE_RATE, 64'd10000);
            1: begin
               set_config(REG_SEED, {$urandom, $urandom});
               set_config(REG_SAMPLE_RATE, 64'd5000);
            end
            2: begin
               set_config(REG_SEED, '1);
               set_config(REG_SAMPLE_RATE, 64'd1);
            end
            3: begin
               set_config(REG_SEED, 64'd1);
               set_config(REG_SAMPLE_RATE, 64'd9999);
            end
            4: set_config(REG_SAMPLE_RATE, '0);
            5: begin
               set_config(REG_SEED, {$urandom, $urandom});
               set_config(REG_SAMPLE_RATE, 64'($urandom_range(1, 9999)));
            end
            default: set_config(REG_SAMPLE_RATE, 64'($urandom_range(0, 16383)));
         endcase
         // last phase runs with no idling on either side
         idle_on <= (p != RANDOM_PHASES - 1);
         pop_pct = (p % 3 == 0) ? 35 : ((p % 3 == 1) ? 50 : 65);
         for (int i = 0; i < PHASE_BEATS; i++) begin
            kind = ($urandom_range(0, 99) < pop_pct) ? REQ_POP : REQ_LOG;
            send_beat(kind, random_event());
            if (p == 1 && i == PHASE_BEATS / 2) wait_for_results();
         end
      end
   endtask

   initial begin : run_tests
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_reset();
      test_directed();
      test_rate_extremes();
      test_receiver_hold();
      test_random();
      wait_for_results();
      repeat (16) @(posedge clock);
      $display("covered %0d request beats: %0d stored, %0d dropped, %0d popped, %0d empty pops,",
               beats_sent, status_hits[ST_STORED], status_hits[ST_DROPPED],
               status_hits[ST_POPPED], status_hits[ST_POP_EMPTY]);
      $display("%0d unsampled; rates 0..10000 with clamped writes, seeds 0/1/all ones, peak fill %0d",
               status_hits[ST_NOT_SAMPLED], deepest_fill);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
